// File: hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

    localparam int SymW  = 8;
    localparam int LenW  = 6;
    localparam int WordW = 32;
    localparam int AccW  = WordW + 7;
    localparam int ShW   = 6;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [LenW-1:0]  len;
        logic [WordW-1:0] word;
    } t_tbl_entry;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SymW-1:0]   addr;
        t_tbl_entry        wdata;
    } t_tbl_req;

endpackage

// File: hw/rtl/hcbp_code_table.sv
module hcbp_code_table #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                  i_clk,
    input  hcbp_pkg::t_tbl_req    i_req,
    output hcbp_pkg::t_tbl_entry  o_rdata
);

    localparam int IdxW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    hcbp_pkg::t_tbl_entry r_mem [SYMBOL_COUNT];
    hcbp_pkg::t_tbl_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[IdxW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr[IdxW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/hcbp_packer.sv
module hcbp_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_action,
    input  logic [hcbp_pkg::SymW-1:0]       i_symbol,
    input  logic [hcbp_pkg::LenW-1:0]       i_code_length,
    input  logic [hcbp_pkg::WordW-1:0]      i_code_bits,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic [3:0]                      o_pad_bits,
    output logic                            o_last,
    output hcbp_pkg::t_tbl_req              o_tbl_req,
    input  hcbp_pkg::t_tbl_entry            i_tbl_rdata
);

    localparam int LimInt = (MAX_CODE_LEN < hcbp_pkg::WordW) ? MAX_CODE_LEN : hcbp_pkg::WordW;
    localparam logic [hcbp_pkg::LenW-1:0] LenLim = hcbp_pkg::LenW'(LimInt);
    localparam logic [hcbp_pkg::SymW:0]   SymLim = (hcbp_pkg::SymW+1)'(SYMBOL_COUNT);

    hcbp_pkg::t_state              r_state, n_state;
    logic [6:0]                    r_pend_bits;
    logic [2:0]                    r_pend_cnt;
    logic [hcbp_pkg::AccW-1:0]     r_acc;
    logic [hcbp_pkg::ShW-1:0]      r_shift;
    logic [7:0]                    r_out_byte;
    logic                          r_byte_valid;
    logic [3:0]                    r_pad_bits;
    logic                          r_last;

    logic                          in_acc, out_acc, sym_ok;
    logic [hcbp_pkg::LenW-1:0]     len_eff;
    logic [hcbp_pkg::WordW-1:0]    word_mask, word;
    logic [hcbp_pkg::AccW-1:0]     acc;
    logic [hcbp_pkg::ShW-1:0]      total, lk_shift, em_shift;
    logic [7:0]                    lk_byte, em_byte, fl_byte;
    logic [6:0]                    pend_mask;
    logic [3:0]                    fl_pad;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign sym_ok  = {1'b0, i_symbol} < SymLim;

    always_comb begin
        len_eff   = (i_tbl_rdata.len > LenLim) ? LenLim : i_tbl_rdata.len;
        word_mask = (len_eff >= hcbp_pkg::LenW'(hcbp_pkg::WordW)) ? '1
                  : ((hcbp_pkg::WordW'(1) << len_eff) - hcbp_pkg::WordW'(1));
        word      = i_tbl_rdata.word & word_mask;
        acc       = ({{hcbp_pkg::WordW{1'b0}}, r_pend_bits} << len_eff)
                  | {7'd0, word};
        total     = {3'd0, r_pend_cnt} + len_eff;
        lk_shift  = total - hcbp_pkg::ShW'(8);
        lk_byte   = 8'(acc >> lk_shift);
        em_shift  = r_shift - hcbp_pkg::ShW'(8);
        em_byte   = 8'(r_acc >> em_shift);
        pend_mask = 7'((8'd1 << total[2:0]) - 8'd1);
        fl_pad    = 4'd8 - {1'b0, r_pend_cnt};
        fl_byte   = 8'({9'd0, r_pend_bits} << fl_pad);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hcbp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        hcbp_pkg::ACT_ENCODE: if (sym_ok) n_state = hcbp_pkg::ST_LOOKUP;
                        hcbp_pkg::ACT_FLUSH:  n_state = hcbp_pkg::ST_EMIT;
                        default:              n_state = hcbp_pkg::ST_IDLE;
                    endcase
                end
            end
            hcbp_pkg::ST_LOOKUP: begin
                n_state = (total >= hcbp_pkg::ShW'(8)) ? hcbp_pkg::ST_EMIT
                                                       : hcbp_pkg::ST_IDLE;
            end
            hcbp_pkg::ST_EMIT: begin
                if (out_acc && r_last) n_state = hcbp_pkg::ST_IDLE;
            end
            default: n_state = hcbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready            = i_rst_n && (r_state == hcbp_pkg::ST_IDLE);
        o_valid            = (r_state == hcbp_pkg::ST_EMIT);
        o_out_byte         = r_out_byte;
        o_byte_valid       = r_byte_valid;
        o_pad_bits         = r_pad_bits;
        o_last             = r_last;
        o_tbl_req.we       = in_acc && (i_action == hcbp_pkg::ACT_LOAD) && sym_ok;
        o_tbl_req.re       = in_acc && (i_action == hcbp_pkg::ACT_ENCODE) && sym_ok;
        o_tbl_req.addr     = i_symbol;
        o_tbl_req.wdata.len  = i_code_length;
        o_tbl_req.wdata.word = i_code_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcbp_pkg::ST_IDLE;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == hcbp_pkg::ST_IDLE && in_acc && i_action == hcbp_pkg::ACT_FLUSH) begin
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
            end else if (r_state == hcbp_pkg::ST_LOOKUP) begin
                r_pend_bits <= acc[6:0] & pend_mask;
                r_pend_cnt  <= total[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            hcbp_pkg::ST_IDLE: begin
                if (in_acc && i_action == hcbp_pkg::ACT_FLUSH) begin
                    r_out_byte   <= (r_pend_cnt == 3'd0) ? 8'd0 : fl_byte;
                    r_byte_valid <= (r_pend_cnt != 3'd0);
                    r_pad_bits   <= fl_pad;
                    r_last       <= 1'b1;
                end
            end
            hcbp_pkg::ST_LOOKUP: begin
                r_acc        <= acc;
                r_shift      <= lk_shift;
                r_out_byte   <= lk_byte;
                r_byte_valid <= 1'b1;
                r_pad_bits   <= 4'd0;
                r_last       <= (lk_shift < hcbp_pkg::ShW'(8));
            end
            hcbp_pkg::ST_EMIT: begin
                if (out_acc && !r_last) begin
                    r_shift    <= em_shift;
                    r_out_byte <= em_byte;
                    r_last     <= (em_shift < hcbp_pkg::ShW'(8));
                end
            end
            default: begin
            end
        endcase
    end

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcbp_pkg::ST_EMIT && i_ready && r_last) |=> (r_state == hcbp_pkg::ST_IDLE))
        else $error("final beat did not return to idle");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input taken while a result is pending");

    a_shift_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcbp_pkg::ST_EMIT && !r_last) |-> (r_shift >= hcbp_pkg::ShW'(8)))
        else $error("accumulator underflow before final byte");

    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcbp_pkg::ST_EMIT && r_pad_bits != 4'd0) |-> r_last)
        else $error("flush beat not marked last");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcbp_pkg::ST_IDLE && $past(r_state == hcbp_pkg::ST_EMIT && r_pad_bits != 4'd0))
        |-> (r_pend_cnt == 3'd0))
        else $error("flush left bits pending");

endmodule

// File: hw/rtl/huffman_code_bit_packer.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_action, i_symbol, i_code_length, i_code_bits
// result    out        o_valid / i_ready   o_out_byte, o_byte_valid, o_pad_bits, o_last
//
// A load writes the code table when accepted; encode and flush items are handled one at a time.
// An encode reads the code table as it is accepted, packs in ST_LOOKUP, then emits 0 to 4 bytes.
// A flush gives its single beat on the cycle after it is accepted.
// Reset clears the pending bits; the code table is not cleared and must be loaded before use.
// A stalled result beat holds its payload and blocks new input until it is taken.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [hcbp_pkg::SymW-1:0]   i_symbol,
    input  logic [hcbp_pkg::LenW-1:0]   i_code_length,
    input  logic [hcbp_pkg::WordW-1:0]  i_code_bits,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_byte_valid,
    output logic [3:0]                  o_pad_bits,
    output logic                        o_last
);

    hcbp_pkg::t_tbl_req   tbl_req;
    hcbp_pkg::t_tbl_entry tbl_rdata;

    hcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_code_bits   (i_code_bits),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_pad_bits    (o_pad_bits),
        .o_last        (o_last),
        .o_tbl_req     (tbl_req),
        .i_tbl_rdata   (tbl_rdata)
    );

endmodule

// File: tb/sv/huffman_code_bit_packer_test.sv
`timescale 1ns / 100ps

module huffman_code_bit_packer_test;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                 act;
        logic [hcbp_pkg::SymW-1:0]  sym;
        logic [hcbp_pkg::LenW-1:0]  len;
        logic [hcbp_pkg::WordW-1:0] bits;
        int                         gap;
        bit                         drain;
    } t_code_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] pad_bits;
        logic       last;
    } t_packed_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic [1:0]                 in_action = hcbp_pkg::ACT_LOAD;
    logic [hcbp_pkg::SymW-1:0]  in_symbol = '0;
    logic [hcbp_pkg::LenW-1:0]  in_code_length = '0;
    logic [hcbp_pkg::WordW-1:0] in_code_bits = '0;
    logic                       out_ready = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic [3:0] o_pad_bits;
    logic       o_last;

    t_code_item   item_q[$];
    t_packed_beat byte_exp_q[$];

    logic [hcbp_pkg::LenW-1:0]  code_len_tbl[256];
    logic [hcbp_pkg::WordW-1:0] code_word_tbl[256];
    logic [6:0]                 pend_bits = '0;
    int unsigned                pend_cnt = 0;

    bit          gen_written[256];
    logic [7:0]  gen_syms[$];

    logic in_fire = 1'b0;
    t_code_item cur_item;
    int gap_left = 0;
    int stall_left = 0;
    int unsigned ready_cyc = 0;
    int unsigned ready_roll;

    int err_cnt = 0;
    int n_load = 0;
    int n_enc = 0;
    int n_flush = 0;
    int n_other = 0;
    int n_beats = 0;

    huffman_code_bit_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .o_ready       (o_ready),
        .i_action      (in_action),
        .i_symbol      (in_symbol),
        .i_code_length (in_code_length),
        .i_code_bits   (in_code_bits),
        .o_valid       (o_valid),
        .i_ready       (out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_pad_bits    (o_pad_bits),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [hcbp_pkg::LenW-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return 6'd0;
        if (r < 55) return hcbp_pkg::LenW'($urandom_range(1, 8));
        if (r < 80) return hcbp_pkg::LenW'($urandom_range(9, 20));
        if (r < 94) return hcbp_pkg::LenW'($urandom_range(21, 32));
        return hcbp_pkg::LenW'($urandom_range(33, 63));
    endfunction

    task automatic add_item(input logic [1:0] act, input logic [7:0] sym,
                            input logic [hcbp_pkg::LenW-1:0] len,
                            input logic [hcbp_pkg::WordW-1:0] bits,
                            input bit no_gap, input bit drain);
        t_code_item it;
        it.act = act;
        it.sym = sym;
        it.len = len;
        it.bits = bits;
        it.gap = no_gap ? 0 : pick_gap();
        it.drain = drain;
        if (act == hcbp_pkg::ACT_LOAD && !gen_written[sym]) begin
            gen_written[sym] = 1'b1;
            gen_syms.push_back(sym);
        end
        item_q.push_back(it);
    endtask

    task automatic pack_code(input logic [1:0] act, input logic [7:0] sym,
                             input logic [hcbp_pkg::LenW-1:0] len_in,
                             input logic [hcbp_pkg::WordW-1:0] bits);
        int unsigned len;
        int unsigned total;
        logic [63:0] acc;
        logic [7:0] tail;
        t_packed_beat b;
        case (act)
            hcbp_pkg::ACT_LOAD: begin
                n_load++;
                code_len_tbl[sym] = len_in;
                code_word_tbl[sym] = bits;
            end
            hcbp_pkg::ACT_ENCODE: begin
                n_enc++;
                len = 32'(code_len_tbl[sym]);
                if (len > 32) len = 32;
                if (len != 0) begin
                    acc = ({57'd0, pend_bits} << len)
                        | ({32'd0, code_word_tbl[sym]} & ((64'd1 << len) - 64'd1));
                    total = pend_cnt + len;
                    while (total >= 8) begin
                        total -= 8;
                        b.out_byte = 8'(acc >> total);
                        b.byte_valid = 1'b1;
                        b.pad_bits = 4'd0;
                        b.last = (total < 8);
                        byte_exp_q.push_back(b);
                    end
                    pend_cnt = total;
                    pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            hcbp_pkg::ACT_FLUSH: begin
                n_flush++;
                if (pend_cnt == 0) begin
                    b.out_byte = 8'd0;
                    b.byte_valid = 1'b0;
                    b.pad_bits = 4'd8;
                end else begin
                    tail = {1'b0, pend_bits};
                    b.out_byte = tail << (8 - pend_cnt);
                    b.byte_valid = 1'b1;
                    b.pad_bits = 4'(8 - pend_cnt);
                end
                b.last = 1'b1;
                byte_exp_q.push_back(b);
                pend_bits = '0;
                pend_cnt = 0;
            end
            default: begin
                n_other++;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            err_cnt++;
        end
    endtask

    task automatic check_beat();
        t_packed_beat b;
        n_beats++;
        if (byte_exp_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual byte %0h valid %0b pad %0d last %0b",
                     $time, o_out_byte, o_byte_valid, o_pad_bits, o_last);
            err_cnt++;
        end else begin
            b = byte_exp_q.pop_front();
            check_field("out_byte", b.out_byte, o_out_byte);
            check_field("byte_valid", 8'(b.byte_valid), 8'(o_byte_valid));
            check_field("pad_bits", 8'(b.pad_bits), 8'(o_pad_bits));
            check_field("last", 8'(b.last), 8'(o_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_fire <= in_valid && o_ready;
            if (o_valid && out_ready) check_beat();
            if (in_valid && o_ready) pack_code(in_action, in_symbol, in_code_length, in_code_bits);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (item_q.size() != 0 &&
                         !(item_q[0].drain && byte_exp_q.size() != 0)) begin
                cur_item = item_q.pop_front();
                in_action <= cur_item.act;
                in_symbol <= cur_item.sym;
                in_code_length <= cur_item.len;
                in_code_bits <= cur_item.bits;
                in_valid <= 1'b1;
                gap_left = cur_item.gap;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        ready_cyc++;
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ((ready_cyc % 1500) < 200) begin
            out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 25) begin
                stall_left = (ready_roll < 3) ? $urandom_range(10, 30) : $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned r;
        bit no_gap;
        logic [7:0] sym;

        // Directed beats: table extremes, saturation, zero length, empty and partial flush.
        add_item(hcbp_pkg::ACT_LOAD, 8'h00, 6'd1, 32'h0000_0001, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_LOAD, 8'h55, 6'd63, 32'hA5A5_A5A5, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_LOAD, 8'hAA, 6'd0, 32'hDEAD_BEEF, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_LOAD, 8'h07, 6'd7, 32'hFFFF_FF55, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_LOAD, 8'h80, 6'd8, 32'h0000_0000, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_FLUSH, 8'h3C, 6'd21, 32'h1234_5678, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'h00, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_FLUSH, 8'h00, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'hFF, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'h07, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'hFF, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'hAA, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(ACT_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'h55, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'h80, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_FLUSH, 8'h00, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_FLUSH, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_LOAD, 8'h07, 6'd32, 32'h8000_0001, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'h07, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_ENCODE, 8'h00, 6'd0, 32'h0, 1'b0, 1'b0);
        add_item(hcbp_pkg::ACT_FLUSH, 8'h00, 6'd0, 32'h0, 1'b0, 1'b0);

        for (int i = 0; i < 350; i++) begin
            no_gap = (i >= 120 && i < 170);
            r = $urandom_range(0, 99);
            if (r < 12 || gen_syms.size() == 0) begin
                sym = 8'($urandom_range(0, 255));
                add_item(hcbp_pkg::ACT_LOAD, sym, pick_len(), $urandom, no_gap, i == 0);
            end else if (r < 80) begin
                sym = gen_syms[$urandom_range(0, gen_syms.size() - 1)];
                add_item(hcbp_pkg::ACT_ENCODE, sym, hcbp_pkg::LenW'($urandom_range(0, 63)),
                         $urandom, no_gap, i == 0 || i == 200);
            end else if (r < 93) begin
                add_item(hcbp_pkg::ACT_FLUSH, 8'($urandom_range(0, 255)),
                         hcbp_pkg::LenW'($urandom_range(0, 63)), $urandom,
                         no_gap, i == 0 || i == 200);
            end else begin
                add_item(ACT_UNUSED, 8'($urandom_range(0, 255)),
                         hcbp_pkg::LenW'($urandom_range(0, 63)), $urandom,
                         no_gap, i == 0);
            end
        end
        add_item(hcbp_pkg::ACT_FLUSH, 8'h00, 6'd0, 32'h0, 1'b0, 1'b0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || in_valid) @(posedge i_clk);
        while (byte_exp_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d loads, %0d encodes, %0d flushes and %0d ignored beats;",
                 n_load, n_enc, n_flush, n_other);
        $display("checked %0d packed output beats under random gaps and stalls.", n_beats);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_code_table.sv
hw/rtl/hcbp_packer.sv
hw/rtl/huffman_code_bit_packer.sv
tb/sv/huffman_code_bit_packer_test.sv
